/* rtl/core/exyz_pkg.sv */
package exyz_pkg;

  localparam int unsigned CoordWidth        = 32;
  localparam int unsigned AngleWidth        = 16;
  localparam int unsigned PhaseWidth        = 32;
  localparam int unsigned AtanEntries       = 24;
  localparam int unsigned RotationStepsDef  = 16;
  localparam int unsigned FractionBitsDef   = 16;
  // trig values: sign, one integer bit, up to 24 fraction bits, growth margin
  localparam int unsigned TrigWidth         = 28;
  localparam logic [31:0] CordicGainQ32     = 32'h9B74EDA8;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [AngleWidth-1:0] angle_t;
  typedef logic signed [TrigWidth-1:0]  trig_t;
  typedef logic signed [PhaseWidth:0]   phase_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    angle_t ax;
    angle_t ay;
    angle_t az;
  } vec_in_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } vec_out_t;

  function automatic logic [31:0] atan_entry(input int unsigned idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/exyz_stream_if.sv */
interface exyz_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/exyz_rotate_core.sv */
// Pipelined datapath: CORDIC sine/cosine for all three angles in parallel,
// one step per stage, then three rotations of a multiply stage and an add-round stage each.
module exyz_rotate_core #(
  parameter int unsigned ROTATION_STEPS = exyz_pkg::RotationStepsDef,
  parameter int unsigned FRACTION_BITS  = exyz_pkg::FractionBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  exyz_pkg::vec_in_t data_i,
  output logic              valid_o,
  output exyz_pkg::vec_out_t data_o
);

  localparam int unsigned NSteps = (ROTATION_STEPS < exyz_pkg::AtanEntries) ?
                                   ROTATION_STEPS : exyz_pkg::AtanEntries;
  localparam int unsigned TW = exyz_pkg::TrigWidth;
  localparam int unsigned PW = exyz_pkg::PhaseWidth + 1;
  localparam logic [63:0] KRound = (64'(exyz_pkg::CordicGainQ32) +
                                    (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
  // rotation stages: 0 mul x, 1 sum x, 2 mul y, 3 sum y, 4 mul z, 5 sum z
  localparam int unsigned RotStages = 6;
  localparam int unsigned Depth = 1 + NSteps + RotStages;

  typedef logic signed [TW-1:0] tr_t;
  typedef logic signed [PW-1:0] ph_t;
  typedef logic signed [63:0]   prod_t;
  typedef logic signed [65:0]   acc_t;

  // one CORDIC lane per angle
  typedef struct packed {
    tr_t x;
    tr_t y;
    ph_t z;
    logic flip;
  } lane_t;

  typedef struct packed {
    exyz_pkg::coord_t x;
    exyz_pkg::coord_t y;
    exyz_pkg::coord_t z;
    lane_t [2:0] ln;
  } cst_t;

  typedef struct packed {
    exyz_pkg::coord_t x;
    exyz_pkg::coord_t y;
    exyz_pkg::coord_t z;
    tr_t [2:0] c;
    tr_t [2:0] s;
    prod_t [3:0] p;
    logic sat;
  } rst_t;

  function automatic lane_t lane_init(input exyz_pkg::angle_t a);
    lane_t l;
    logic [31:0] t;
    logic [31:0] tq;
    logic        f;
    t  = {a, 16'd0};
    tq = t + 32'h40000000;
    f  = tq[31];
    if (f) t = t + 32'h80000000;
    l.x = TW'(KRound);
    l.y = '0;
    l.z = {t[31], t};
    l.flip = f;
    return l;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input int unsigned i);
    lane_t r;
    ph_t   at;
    at = ph_t'(exyz_pkg::atan_entry(i));
    r = l;
    if (!l.z[PW-1]) begin
      r.x = l.x - (l.y >>> i);
      r.y = l.y + (l.x >>> i);
      r.z = l.z - at;
    end else begin
      r.x = l.x + (l.y >>> i);
      r.y = l.y - (l.x >>> i);
      r.z = l.z + at;
    end
    return r;
  endfunction

  function automatic logic signed [32:0] scale_sat(input acc_t acc, output logic clip);
    acc_t v;
    logic signed [32:0] r;
    v = (acc + (acc_t'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    clip = 1'b0;
    if (v > acc_t'(32'sh7FFFFFFF)) begin
      r = 33'sh07FFFFFFF;
      clip = 1'b1;
    end else if (v < -acc_t'(64'sh80000000)) begin
      r = -33'sh080000000;
      clip = 1'b1;
    end else begin
      r = v[32:0];
    end
    return r;
  endfunction

  logic [Depth-1:0] vld_q;
  cst_t             cs_q [NSteps+1];
  rst_t             rs_q [RotStages];

  // advance valid bits whenever the pipeline is enabled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  // CORDIC front end: fold angle, then one step a stage
  always_ff @(posedge clk_i) begin
    cst_t nx;
    if (en_i) begin
      nx.x     = data_i.x;
      nx.y     = data_i.y;
      nx.z     = data_i.z;
      nx.ln[0] = lane_init(data_i.ax);
      nx.ln[1] = lane_init(data_i.ay);
      nx.ln[2] = lane_init(data_i.az);
      cs_q[0] <= nx;
      for (int unsigned i = 0; i < NSteps; i++) begin
        nx       = cs_q[i];
        nx.ln[0] = lane_step(cs_q[i].ln[0], i);
        nx.ln[1] = lane_step(cs_q[i].ln[1], i);
        nx.ln[2] = lane_step(cs_q[i].ln[2], i);
        cs_q[i+1] <= nx;
      end
    end
  end

  cst_t cl;
  tr_t [2:0] cos_w, sin_w;
  always_comb begin
    cl = cs_q[NSteps];
    for (int k = 0; k < 3; k++) begin
      cos_w[k] = cl.ln[k].flip ? -cl.ln[k].x : cl.ln[k].x;
      sin_w[k] = cl.ln[k].flip ? -cl.ln[k].y : cl.ln[k].y;
    end
  end

  // rotation stages: products registered, then sum, round, clip
  always_ff @(posedge clk_i) begin
    acc_t a0, a1;
    logic signed [32:0] v0, v1;
    logic k0, k1;
    rst_t n;
    if (en_i) begin
      // x rotation products
      n.x = cl.x; n.y = cl.y; n.z = cl.z;
      n.c = cos_w; n.s = sin_w; n.sat = 1'b0;
      n.p[0] = prod_t'(cl.y) * prod_t'(cos_w[0]);
      n.p[1] = -(prod_t'(cl.z) * prod_t'(sin_w[0]));
      n.p[2] = prod_t'(cl.y) * prod_t'(sin_w[0]);
      n.p[3] = prod_t'(cl.z) * prod_t'(cos_w[0]);
      rs_q[0] <= n;
      // x rotation result
      a0 = acc_t'(rs_q[0].p[0]) + acc_t'(rs_q[0].p[1]);
      a1 = acc_t'(rs_q[0].p[2]) + acc_t'(rs_q[0].p[3]);
      v0 = scale_sat(a0, k0);
      v1 = scale_sat(a1, k1);
      n = rs_q[0];
      n.y = v0[31:0];
      n.z = v1[31:0];
      n.sat = rs_q[0].sat | k0 | k1;
      rs_q[1] <= n;
      // y rotation products
      n = rs_q[1];
      n.p[0] = prod_t'(rs_q[1].x) * prod_t'(rs_q[1].c[1]);
      n.p[1] = prod_t'(rs_q[1].z) * prod_t'(rs_q[1].s[1]);
      n.p[2] = prod_t'(rs_q[1].z) * prod_t'(rs_q[1].c[1]);
      n.p[3] = -(prod_t'(rs_q[1].x) * prod_t'(rs_q[1].s[1]));
      rs_q[2] <= n;
      a0 = acc_t'(rs_q[2].p[0]) + acc_t'(rs_q[2].p[1]);
      a1 = acc_t'(rs_q[2].p[2]) + acc_t'(rs_q[2].p[3]);
      v0 = scale_sat(a0, k0);
      v1 = scale_sat(a1, k1);
      n = rs_q[2];
      n.x = v0[31:0];
      n.z = v1[31:0];
      n.sat = rs_q[2].sat | k0 | k1;
      rs_q[3] <= n;
      // z rotation products
      n = rs_q[3];
      n.p[0] = prod_t'(rs_q[3].x) * prod_t'(rs_q[3].c[2]);
      n.p[1] = -(prod_t'(rs_q[3].y) * prod_t'(rs_q[3].s[2]));
      n.p[2] = prod_t'(rs_q[3].x) * prod_t'(rs_q[3].s[2]);
      n.p[3] = prod_t'(rs_q[3].y) * prod_t'(rs_q[3].c[2]);
      rs_q[4] <= n;
      a0 = acc_t'(rs_q[4].p[0]) + acc_t'(rs_q[4].p[1]);
      a1 = acc_t'(rs_q[4].p[2]) + acc_t'(rs_q[4].p[3]);
      v0 = scale_sat(a0, k0);
      v1 = scale_sat(a1, k1);
      n = rs_q[4];
      n.x = v0[31:0];
      n.y = v1[31:0];
      n.sat = rs_q[4].sat | k0 | k1;
      rs_q[5] <= n;
    end
  end

  assign valid_o  = vld_q[Depth-1];
  assign data_o.x = rs_q[5].x;
  assign data_o.y = rs_q[5].y;
  assign data_o.z = rs_q[5].z;
  assign data_o.sat = rs_q[5].sat;

endmodule

/* rtl/core/euler_xyz_vector_rotator_unit.sv */
// Euler XYZ vector rotator.
// Input channel in_i carries a Q15.16 vector and three binary angles; output
// channel out_o carries the rotated, saturated vector and a clip flag.
// A beat is taken on in_i when valid and ready are both high; one beat
// leaves on out_o for every beat taken, in order.
// Throughput: one beat per cycle while in_i.ready is high. A beat passes
// an angle-fold stage, the CORDIC chain of one iteration per stage
// (ROTATION_STEPS, capped at 24), three rotations of one multiply stage and
// one sum-round stage each, and then the output register.
// The pipeline advances as a whole whenever the output buffer has a free
// entry or the core holds no beat; when the receiver stalls, the two-entry
// output buffer takes the beat in flight, then in_i drops ready, so nothing
// is lost. in_i.ready depends on registers only, never on out_o.ready.
// Reset clears all valid bits and the output buffer; data needs no reset.
module euler_xyz_vector_rotator_unit #(
  parameter int unsigned ROTATION_STEPS = exyz_pkg::RotationStepsDef,
  parameter int unsigned FRACTION_BITS  = exyz_pkg::FractionBitsDef
) (
  input logic clk_i,
  input logic rst_ni,
  exyz_stream_if.sink   in_i,
  exyz_stream_if.source out_o
);

  logic               core_vld;
  exyz_pkg::vec_out_t core_dat;
  logic               en;
  exyz_pkg::vec_out_t buf_q [2];
  logic [1:0]         cnt_q;
  logic               push, pop;

  // advance only when the buffer has room for whatever leaves the core
  assign en = (cnt_q != 2'd2) || !core_vld;
  assign in_i.ready = en;

  exyz_rotate_core #(
    .ROTATION_STEPS(ROTATION_STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_i.valid),
    .data_i (in_i.data),
    .valid_o(core_vld),
    .data_o (core_dat)
  );

  assign push = en && core_vld;
  assign pop  = out_o.ready && (cnt_q != 2'd0);

  // hold results in a small in-order buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push && cnt_q == 2'd1) buf_q[0] <= core_dat;
      else                       buf_q[0] <= buf_q[1];
      if (push && cnt_q == 2'd2) buf_q[1] <= core_dat;
    end else if (push) begin
      buf_q[cnt_q[0]] <= core_dat;
    end
  end

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = buf_q[0];

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("output buffer overrun");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !out_o.ready && core_vld) |-> !in_i.ready)
    else $error("accepting while full");
  a_valid_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> out_o.valid)
    else $error("result lost");

endmodule

/* bench/exyz_tb_if.sv */
package exyz_tb_pkg;

  // one expected result beat
  typedef struct packed {
    exyz_pkg::coord_t x;
    exyz_pkg::coord_t y;
    exyz_pkg::coord_t z;
    logic             sat;
  } rot_expect_t;
endpackage

/* bench/tb.sv */
module tb;

  localparam int unsigned Steps    = exyz_pkg::RotationStepsDef;
  localparam int unsigned FracBits = exyz_pkg::FractionBitsDef;
  localparam int unsigned Latency  =
    ((Steps > exyz_pkg::AtanEntries) ? exyz_pkg::AtanEntries : Steps) + 8;
  localparam int unsigned Limit    = 400000;

  logic clk_i;
  logic rst_ni;

  exyz_stream_if #(.T(exyz_pkg::vec_in_t))  in_if ();
  exyz_stream_if #(.T(exyz_pkg::vec_out_t)) out_if ();

  euler_xyz_vector_rotator_unit #(
    .ROTATION_STEPS(Steps),
    .FRACTION_BITS (FracBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  exyz_tb_pkg::rot_expect_t rotated_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_off;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Trig pair of one binary angle by CORDIC
  function automatic void cordic_sincos(input exyz_pkg::angle_t ang, output longint c,
                                        output longint s);
    logic [31:0] t;
    bit          flip;
    longint      cx, sy, z, nx;
    longint      gain;
    t    = {ang, 16'h0000};
    flip = 1'b0;
    if (((t + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      t    = t + 32'h8000_0000;
      flip = 1'b1;
    end
    z    = longint'($signed(t));
    gain = 64'h9B74EDA8;
    cx   = (gain + (64'd1 << (31 - FracBits))) >> (32 - FracBits);
    sy   = 0;
    for (int i = 0; i < Steps && i < exyz_pkg::AtanEntries; i++) begin
      if (z >= 0) begin
        nx = cx - (sy >>> i);
        sy = sy + (cx >>> i);
        z  = z - longint'(exyz_pkg::atan_entry(i));
      end else begin
        nx = cx + (sy >>> i);
        sy = sy - (cx >>> i);
        z  = z + longint'(exyz_pkg::atan_entry(i));
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      sy = -sy;
    end
    c = cx;
    s = sy;
  endfunction

  // Round half up, scale back and clip one coordinate
  function automatic longint round_clip(input longint acc, inout bit clip);
    longint v;
    v = (acc + (longint'(1) << (FracBits - 1))) >>> FracBits;
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      v    = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      clip = 1'b1;
      v    = -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic exyz_tb_pkg::rot_expect_t rotate_xyz(input exyz_pkg::vec_in_t v);
    longint                   x, y, z, c, s, a, b;
    bit                       clip;
    exyz_tb_pkg::rot_expect_t r;
    clip = 1'b0;
    x = v.x;
    y = v.y;
    z = v.z;
    cordic_sincos(v.ax, c, s);
    a = round_clip(y * c - z * s, clip);
    b = round_clip(y * s + z * c, clip);
    y = a;
    z = b;
    cordic_sincos(v.ay, c, s);
    a = round_clip(x * c + z * s, clip);
    b = round_clip(z * c - x * s, clip);
    x = a;
    z = b;
    cordic_sincos(v.az, c, s);
    a = round_clip(x * c - y * s, clip);
    b = round_clip(x * s + y * c, clip);
    r.x   = exyz_pkg::coord_t'(a);
    r.y   = exyz_pkg::coord_t'(b);
    r.z   = exyz_pkg::coord_t'(z);
    r.sat = clip;
    return r;
  endfunction

  // Send one beat, at times with a random gap in front
  task automatic send_vector(input exyz_pkg::vec_in_t v);
    int unsigned gap;
    if (!idle_off && $urandom_range(3) == 0) begin
      gap = $urandom_range(12, 1);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    rotated_q.push_back(rotate_xyz(v));
  endtask

  function automatic exyz_pkg::coord_t rand_coord();
    case ($urandom_range(5))
      0: return exyz_pkg::coord_t'($urandom);
      1: return exyz_pkg::coord_t'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
      2: return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      3: return exyz_pkg::coord_t'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
      4: return 32'sd0;
      default: return exyz_pkg::coord_t'($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  function automatic exyz_pkg::angle_t rand_angle();
    case ($urandom_range(4))
      0: return exyz_pkg::angle_t'({$urandom_range(3), 14'h0000});
      1: return exyz_pkg::angle_t'({$urandom_range(3), 14'h0000} + $urandom_range(2) - 1);
      default: return exyz_pkg::angle_t'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    exyz_pkg::vec_in_t v;
    exyz_pkg::coord_t  cv[4] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 32'sd0};
    exyz_pkg::angle_t  av[6] = '{16'sh0000, 16'sh4000, 16'sh7FFF, 16'sh8000, 16'shC000,
                                 16'shBFFF};
    // extreme, unit and zero coordinates with each special angle on each axis
    for (int i = 0; i < 6; i++) begin
      v = '{x: cv[i % 4], y: cv[(i + 1) % 4], z: cv[(i + 2) % 4],
            ax: av[i], ay: av[(i + 2) % 6], az: av[(i + 4) % 6]};
      send_vector(v);
    end
    for (int i = 0; i < 6; i++) begin
      v = '{x: 32'sh0001_0000, y: 32'sh0002_0000, z: 32'sh0003_0000,
            ax: av[i], ay: av[i], az: av[i]};
      send_vector(v);
    end
    // full-scale vectors that must clip, then a small vector
    v = '{x: 32'sh7FFF_FFFF, y: 32'sh7FFF_FFFF, z: 32'sh7FFF_FFFF,
          ax: 16'sh2000, ay: 16'sh2000, az: 16'sh2000};
    send_vector(v);
    v = '{x: 32'sh8000_0000, y: 32'sh8000_0000, z: 32'sh8000_0000,
          ax: 16'shE000, ay: 16'shE000, az: 16'shE000};
    send_vector(v);
    v = '{x: 32'shFFFF_FFFF, y: 32'sh0000_0001, z: 32'shFFFF_FFFF,
          ax: 16'sh1234, ay: 16'shEDCB, az: 16'sh8000};
    send_vector(v);
  endtask

  task automatic test_random(input int unsigned n);
    exyz_pkg::vec_in_t v;
    for (int unsigned i = 0; i < n; i++) begin
      v = '{x: rand_coord(), y: rand_coord(), z: rand_coord(),
            ax: rand_angle(), ay: rand_angle(), az: rand_angle()};
      send_vector(v);
    end
  endtask

  task automatic test_streaming(input int unsigned n);
    idle_off = 1'b1;
    test_random(n);
  endtask

  // Receiver: check each beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rotated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", out_if.data);
      end else if (out_if.data.x !== rotated_q[0].x
                   || out_if.data.y !== rotated_q[0].y
                   || out_if.data.z !== rotated_q[0].z
                   || out_if.data.sat !== rotated_q[0].sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                   rotated_q[0].x, rotated_q[0].y, rotated_q[0].z, rotated_q[0].sat,
                   out_if.data.x, out_if.data.y, out_if.data.z, out_if.data.sat);
        void'(rotated_q.pop_front());
      end else begin
        void'(rotated_q.pop_front());
      end
    end
  end

  // stall bursts on the receiving side
  initial begin
    int unsigned len;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!idle_off && $urandom_range(3) == 0) begin
        len = $urandom_range(12, 1);
        out_if.ready <= 1'b0;
      end else begin
        len = $urandom_range(16, 1);
        out_if.ready <= 1'b1;
      end
      repeat (len) @(posedge clk_i);
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("** euler_xyz_vector_rotator_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    idle_off     = 1'b0;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1200);
    test_streaming(300);
    in_if.valid <= 1'b0;
    // drain
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("** euler_xyz_vector_rotator_unit: PASSED **");
    end else begin
      $display("** euler_xyz_vector_rotator_unit: FAILED **");
    end
    $finish;
  end
endmodule
